### rtl/csps_pkg.sv
// Shared types and constants for the cube surface particle step block.
// Holds the item structs, edge codes, sequencer states and the control bundle.
// No dependencies.
package csps_pkg;

    localparam int PARTICLES_DEF = 1024;
    localparam int CUBE_MAX_DEF  = 63;
    localparam int FRAC_BITS_DEF = 8;

    localparam int IDX_W    = 10;
    localparam int POS_IN_W = 14;
    localparam int VEL_W    = 16;
    localparam int PIX_W    = 6;
    localparam int AGE_W    = 9;
    localparam int EDGE_W   = 4;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 9'd260;
    localparam logic [AGE_W-1:0] AGE_MAX       = 9'd511;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [EDGE_W-1:0] {
        EDGE_FRONT_RIGHT,
        EDGE_RIGHT_BACK,
        EDGE_BACK_LEFT,
        EDGE_LEFT_FRONT,
        EDGE_TOP_FRONT,
        EDGE_TOP_RIGHT,
        EDGE_TOP_BACK,
        EDGE_TOP_LEFT,
        EDGE_BOTTOM_FRONT,
        EDGE_BOTTOM_RIGHT,
        EDGE_BOTTOM_BACK,
        EDGE_BOTTOM_LEFT,
        EDGE_NONE
    } edge_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_ISSUE,
        S_LOAD,
        S_ACCEL,
        S_MOVE,
        S_ROUND,
        S_SNAP,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic                       opcode;
        logic [IDX_W-1:0]           particle_index;
        logic [POS_IN_W-1:0]        pos_x;
        logic [POS_IN_W-1:0]        pos_y;
        logic [POS_IN_W-1:0]        pos_z;
        logic signed [VEL_W-1:0]    vel_x;
        logic signed [VEL_W-1:0]    vel_y;
        logic signed [VEL_W-1:0]    vel_z;
        logic signed [VEL_W-1:0]    acc_x;
        logic signed [VEL_W-1:0]    acc_y;
        logic signed [VEL_W-1:0]    acc_z;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [PIX_W-1:0] pixel_z;
        logic             expired;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic load_stage;
        logic accel_stage;
        logic move_stage;
        logic round_stage;
        logic snap_stage;
    } ctrl_t;

endpackage

### rtl/csps_store.sv
// Particle table memory: one write port, one read port, registered read data.
// Generic width and depth; no dependencies.
module csps_store #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/csps_datapath.sv
// Step and load arithmetic for one particle, one stage per sequencer state.
// Depends on csps_pkg for widths, edge codes and the control bundle.
module csps_datapath #(
    parameter int CUBE_MAX  = csps_pkg::CUBE_MAX_DEF,
    parameter int FRAC_BITS = csps_pkg::FRAC_BITS_DEF,
    parameter int PW        = $clog2(csps_pkg::CUBE_MAX_DEF + 1) + csps_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  csps_pkg::ctrl_t                    ctrl,
    input  csps_pkg::in_item_t                 cmd,
    input  logic [csps_pkg::AGE_W-1:0]         age_limit,
    input  logic [PW-1:0]                      q_pos [3],
    input  logic signed [csps_pkg::VEL_W-1:0]  q_vel [3],
    input  csps_pkg::edge_t                    q_edge,
    input  logic [csps_pkg::AGE_W-1:0]         q_age,
    input  logic                               q_exp,
    output logic [PW-1:0]                      wr_pos [3],
    output logic signed [csps_pkg::VEL_W-1:0]  wr_vel [3],
    output csps_pkg::edge_t                    wr_edge,
    output logic [csps_pkg::AGE_W-1:0]         wr_age,
    output logic                               wr_exp,
    output logic [PW-FRAC_BITS-1:0]            pix [3]
);

    localparam int RW = PW - FRAC_BITS;
    localparam int VW = csps_pkg::VEL_W;
    localparam int SW = ((PW > VW) ? PW : VW) + 2;
    localparam int unsigned POS_TOP_I = CUBE_MAX << FRAC_BITS;
    localparam logic [PW-1:0] POS_TOP = PW'(POS_TOP_I);
    localparam logic signed [SW-1:0] POS_TOP_S = SW'(POS_TOP_I);
    localparam logic [PW-1:0] HALF = PW'(1 << (FRAC_BITS - 1));
    localparam logic [RW-1:0] R_MAX = RW'(CUBE_MAX);

    function automatic logic [RW-1:0] round_pix(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + HALF;
        return s[PW-1:FRAC_BITS];
    endfunction

    function automatic logic signed [VW-1:0] sat16(input logic signed [VW:0] v);
        if (v > 17'sd32767)
            return 16'sh7FFF;
        else if (v < -17'sd32768)
            return -16'sh8000;
        else
            return v[VW-1:0];
    endfunction

    function automatic csps_pkg::edge_t find_edge(input logic [RW-1:0] rx,
                                                  input logic [RW-1:0] ry,
                                                  input logic [RW-1:0] rz);
        logic x0, xm, y0, ym, z0, zm;
        x0 = (rx == '0);
        xm = (rx == R_MAX);
        y0 = (ry == '0);
        ym = (ry == R_MAX);
        z0 = (rz == '0);
        zm = (rz == R_MAX);
        if (xm && y0) return csps_pkg::EDGE_FRONT_RIGHT;
        if (xm && ym) return csps_pkg::EDGE_RIGHT_BACK;
        if (x0 && ym) return csps_pkg::EDGE_BACK_LEFT;
        if (x0 && y0) return csps_pkg::EDGE_LEFT_FRONT;
        if (y0 && z0) return csps_pkg::EDGE_TOP_FRONT;
        if (xm && z0) return csps_pkg::EDGE_TOP_RIGHT;
        if (ym && z0) return csps_pkg::EDGE_TOP_BACK;
        if (x0 && z0) return csps_pkg::EDGE_TOP_LEFT;
        if (y0 && zm) return csps_pkg::EDGE_BOTTOM_FRONT;
        if (xm && zm) return csps_pkg::EDGE_BOTTOM_RIGHT;
        if (ym && zm) return csps_pkg::EDGE_BOTTOM_BACK;
        if (x0 && zm) return csps_pkg::EDGE_BOTTOM_LEFT;
        return csps_pkg::EDGE_NONE;
    endfunction

    logic [csps_pkg::POS_IN_W-1:0] pos_in_reg [3];
    logic signed [VW-1:0]          vel_in_reg [3];
    logic signed [VW-1:0]          acc_reg    [3];
    logic [PW-1:0]                 p_reg      [3];
    logic signed [VW-1:0]          v_reg      [3];
    logic [RW-1:0]                 r_reg      [3];
    csps_pkg::edge_t               edge_old_reg;
    csps_pkg::edge_t               edge_reg;
    logic                          hit_reg;
    logic [csps_pkg::AGE_W-1:0]    age_reg;
    logic                          exp_reg;

    logic [PW-1:0]        p_ld  [3];
    logic [RW-1:0]        r_ld  [3];
    logic [RW-1:0]        r_old [3];
    logic [2:0]           in_plane;
    logic signed [VW-1:0] v_acc [3];
    logic signed [SW-1:0] s_mv  [3];
    logic [PW-1:0]        p_mv  [3];
    logic [RW-1:0]        r_rnd [3];
    csps_pkg::edge_t      edge_next;
    logic                 hit_next;
    logic signed [VW-1:0] v_sw  [3];
    logic signed [VW-1:0] v_sn  [3];
    logic [PW-1:0]        p_sn  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (32'(pos_in_reg[i]) > POS_TOP_I)
                p_ld[i] = POS_TOP;
            else
                p_ld[i] = PW'(pos_in_reg[i]);
            r_ld[i] = round_pix(p_ld[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_old[i] = round_pix(q_pos[i]);
        end
        if (r_old[0] == '0 || r_old[0] == R_MAX)
            in_plane = 3'b110;
        else if (r_old[1] == '0 || r_old[1] == R_MAX)
            in_plane = 3'b101;
        else if (r_old[2] == '0 || r_old[2] == R_MAX)
            in_plane = 3'b011;
        else
            in_plane = 3'b000;
        for (int i = 0; i < 3; i++)
        begin
            if (in_plane[i])
                v_acc[i] = sat16((VW+1)'(q_vel[i]) + (VW+1)'(acc_reg[i]));
            else
                v_acc[i] = q_vel[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_mv[i] = $signed({{(SW-PW){1'b0}}, p_reg[i]}) + SW'(v_reg[i]);
            if (s_mv[i] < 0)
                p_mv[i] = '0;
            else if (s_mv[i] > POS_TOP_S)
                p_mv[i] = POS_TOP;
            else
                p_mv[i] = s_mv[i][PW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_rnd[i] = round_pix(p_reg[i]);
        end
        edge_next = find_edge(r_rnd[0], r_rnd[1], r_rnd[2]);
        hit_next  = (edge_next != csps_pkg::EDGE_NONE) && (edge_next != edge_old_reg);
    end

    always_comb
    begin
        v_sw[0] = v_reg[0];
        v_sw[1] = v_reg[1];
        v_sw[2] = v_reg[2];
        case (edge_reg)
            csps_pkg::EDGE_TOP_RIGHT, csps_pkg::EDGE_TOP_LEFT,
            csps_pkg::EDGE_BOTTOM_RIGHT, csps_pkg::EDGE_BOTTOM_LEFT:
            begin
                v_sw[0] = v_reg[2];
                v_sw[2] = v_reg[0];
            end
            csps_pkg::EDGE_TOP_FRONT, csps_pkg::EDGE_TOP_BACK,
            csps_pkg::EDGE_BOTTOM_FRONT, csps_pkg::EDGE_BOTTOM_BACK:
            begin
                v_sw[1] = v_reg[2];
                v_sw[2] = v_reg[1];
            end
            default:
            begin
                v_sw[0] = v_reg[1];
                v_sw[1] = v_reg[0];
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            p_sn[i] = {r_reg[i], {FRAC_BITS{1'b0}}};
            if ((r_reg[i] == '0 && v_sw[i] < 0) || (r_reg[i] == R_MAX && v_sw[i] > 0))
                v_sn[i] = sat16(-((VW+1)'(v_sw[i])));
            else
                v_sn[i] = v_sw[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            pos_in_reg[0] <= cmd.pos_x;
            pos_in_reg[1] <= cmd.pos_y;
            pos_in_reg[2] <= cmd.pos_z;
            vel_in_reg[0] <= cmd.vel_x;
            vel_in_reg[1] <= cmd.vel_y;
            vel_in_reg[2] <= cmd.vel_z;
            acc_reg[0]    <= cmd.acc_x;
            acc_reg[1]    <= cmd.acc_y;
            acc_reg[2]    <= cmd.acc_z;
        end
        if (ctrl.load_stage)
        begin
            p_reg    <= p_ld;
            v_reg    <= vel_in_reg;
            r_reg    <= r_ld;
            edge_reg <= csps_pkg::EDGE_NONE;
            age_reg  <= '0;
            exp_reg  <= 1'b0;
        end
        if (ctrl.accel_stage)
        begin
            p_reg        <= q_pos;
            v_reg        <= v_acc;
            edge_old_reg <= q_edge;
            age_reg      <= q_age;
            exp_reg      <= q_exp;
        end
        if (ctrl.move_stage)
        begin
            p_reg <= p_mv;
        end
        if (ctrl.round_stage)
        begin
            r_reg    <= r_rnd;
            edge_reg <= edge_next;
            hit_reg  <= hit_next;
            exp_reg  <= exp_reg | (age_reg > age_limit);
            if (age_reg != csps_pkg::AGE_MAX)
                age_reg <= age_reg + 1'b1;
        end
        if (ctrl.snap_stage && hit_reg)
        begin
            p_reg <= p_sn;
            v_reg <= v_sn;
        end
    end

    assign wr_pos  = p_reg;
    assign wr_vel  = v_reg;
    assign wr_edge = edge_reg;
    assign wr_age  = age_reg;
    assign wr_exp  = exp_reg;
    assign pix     = r_reg;

endmodule

### rtl/cube_surface_particle_step_core.sv
// Sequence: a load passes through LOAD and WRITE, a step through ACCEL, MOVE, ROUND, SNAP
// and WRITE; WRITE waits while an earlier result is not taken, then registers the result.
// One item at a time, as a read-modify-write on the single particle table memory.
// An index at or above PARTICLES first passes through index reduction in S_MOD and S_ISSUE.
// Reset clears the sequencer and output valid and sets age_limit to 260;
// table entries are undefined until loaded.
module cube_surface_particle_step_core #(
    parameter int PARTICLES = csps_pkg::PARTICLES_DEF,
    parameter int CUBE_MAX  = csps_pkg::CUBE_MAX_DEF,
    parameter int FRAC_BITS = csps_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  csps_pkg::in_item_t         cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output csps_pkg::out_item_t        rsp,
    input  logic                       cfg_we,
    input  logic [csps_pkg::AGE_W-1:0] cfg_wdata
);

    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int PW = $clog2(CUBE_MAX + 1) + FRAC_BITS;
    localparam int RW = PW - FRAC_BITS;
    localparam int VW = csps_pkg::VEL_W;
    localparam int EW = 3 * PW + 3 * VW + csps_pkg::EDGE_W + csps_pkg::AGE_W + 1;
    localparam int IW = csps_pkg::IDX_W;
    localparam int KW = $clog2(IW);
    localparam int RS = 20;
    localparam int unsigned RECIP = (1 << RS) / PARTICLES;

    csps_pkg::state_t            state_reg, state_next;
    logic [IW-1:0]               rem_reg, rem_next;
    logic [IW-1:0]               quo_reg, quo_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [IW-1:0]               idx_reg;
    logic                        op_reg;
    logic [csps_pkg::AGE_W-1:0]  age_limit_reg;
    logic                        rsp_valid_reg, rsp_valid_next;
    csps_pkg::out_item_t         rsp_reg;
    logic                        rsp_load;
    logic                        mem_we;
    logic [31:0]                 mod_mul;
    logic [31:0]                 mod_sub;
    csps_pkg::ctrl_t             ctrl;

    logic [AW-1:0]               rd_addr;
    logic [EW-1:0]               mem_wdata, mem_rdata;

    logic [PW-1:0]               q_pos [3];
    logic signed [VW-1:0]        q_vel [3];
    logic [csps_pkg::EDGE_W-1:0] q_edge_raw;
    logic [csps_pkg::AGE_W-1:0]  q_age;
    logic                        q_exp;
    logic [PW-1:0]               wr_pos [3];
    logic signed [VW-1:0]        wr_vel [3];
    csps_pkg::edge_t             wr_edge;
    logic [csps_pkg::AGE_W-1:0]  wr_age;
    logic                        wr_exp;
    logic [RW-1:0]               pix [3];

    assign rd_addr = (state_reg == csps_pkg::S_IDLE) ? AW'(cmd.particle_index) : AW'(rem_reg);
    assign mem_wdata = {wr_exp, wr_age, wr_edge, wr_vel[2], wr_vel[1], wr_vel[0],
                        wr_pos[2], wr_pos[1], wr_pos[0]};
    assign {q_exp, q_age, q_edge_raw, q_vel[2], q_vel[1], q_vel[0],
            q_pos[2], q_pos[1], q_pos[0]} = mem_rdata;

    assign mod_mul = 32'(rem_reg) * RECIP;
    assign mod_sub = 32'(quo_reg) * 32'(PARTICLES);

    csps_store #(
        .DATA_W (EW),
        .DEPTH  (PARTICLES),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(rem_reg)),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    csps_datapath #(
        .CUBE_MAX  (CUBE_MAX),
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW)
    ) u_datapath (
        .clk       (clk),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .age_limit (age_limit_reg),
        .q_pos     (q_pos),
        .q_vel     (q_vel),
        .q_edge    (csps_pkg::edge_t'(q_edge_raw)),
        .q_age     (q_age),
        .q_exp     (q_exp),
        .wr_pos    (wr_pos),
        .wr_vel    (wr_vel),
        .wr_edge   (wr_edge),
        .wr_age    (wr_age),
        .wr_exp    (wr_exp),
        .pix       (pix)
    );

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        cmd_ready  = 1'b0;
        ctrl       = '0;
        mem_we     = 1'b0;
        rsp_load   = 1'b0;
        case (state_reg)
            csps_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.capture = 1'b1;
                    rem_next     = cmd.particle_index;
                    k_next       = KW'(2);
                    if (32'(cmd.particle_index) >= 32'(PARTICLES))
                        state_next = csps_pkg::S_MOD;
                    else if (cmd.opcode == csps_pkg::OP_STEP)
                        state_next = csps_pkg::S_ACCEL;
                    else
                        state_next = csps_pkg::S_LOAD;
                end
            end
            csps_pkg::S_MOD:
            begin
                if (k_reg == KW'(2))
                    quo_next = mod_mul[IW+RS-1:RS];
                else if (k_reg == KW'(1))
                    rem_next = rem_reg - mod_sub[IW-1:0];
                else
                begin
                    if (32'(rem_reg) >= 32'(PARTICLES))
                        rem_next = rem_reg - IW'(PARTICLES);
                    state_next = csps_pkg::S_ISSUE;
                end
                if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            csps_pkg::S_ISSUE:
            begin
                if (op_reg == csps_pkg::OP_STEP)
                    state_next = csps_pkg::S_ACCEL;
                else
                    state_next = csps_pkg::S_LOAD;
            end
            csps_pkg::S_LOAD:
            begin
                ctrl.load_stage = 1'b1;
                state_next      = csps_pkg::S_WRITE;
            end
            csps_pkg::S_ACCEL:
            begin
                ctrl.accel_stage = 1'b1;
                state_next       = csps_pkg::S_MOVE;
            end
            csps_pkg::S_MOVE:
            begin
                ctrl.move_stage = 1'b1;
                state_next      = csps_pkg::S_ROUND;
            end
            csps_pkg::S_ROUND:
            begin
                ctrl.round_stage = 1'b1;
                state_next       = csps_pkg::S_SNAP;
            end
            csps_pkg::S_SNAP:
            begin
                ctrl.snap_stage = 1'b1;
                state_next      = csps_pkg::S_WRITE;
            end
            csps_pkg::S_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    mem_we     = 1'b1;
                    rsp_load   = 1'b1;
                    state_next = csps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csps_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            age_limit_reg <= csps_pkg::AGE_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                age_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        k_reg   <= k_next;
        if (ctrl.capture)
        begin
            idx_reg <= cmd.particle_index;
            op_reg  <= cmd.opcode;
        end
        if (rsp_load)
        begin
            rsp_reg.out_index <= idx_reg;
            rsp_reg.pixel_x   <= csps_pkg::PIX_W'(pix[0]);
            rsp_reg.pixel_y   <= csps_pkg::PIX_W'(pix[1]);
            rsp_reg.pixel_z   <= csps_pkg::PIX_W'(pix[2]);
            rsp_reg.expired   <= wr_exp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/csps_check.sv
// Port-level checks for cube_surface_particle_step_core, bound to the top level.
// Depends on csps_pkg for the item structs and opcodes.
module csps_check #(
    parameter int PARTICLES = csps_pkg::PARTICLES_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input csps_pkg::in_item_t  cmd,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input csps_pkg::out_item_t rsp
);

    logic cmd_xfer;
    logic rsp_xfer;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd_ready)
        else $error("second item taken while one is in work");

    a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_xfer && cmd_ready |=> !rsp_valid)
        else $error("result appeared with no item in work");

    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer && cmd.opcode == csps_pkg::OP_LOAD && !rsp_valid
            && 32'(cmd.particle_index) < 32'(PARTICLES)
        |-> ##3 rsp_valid && rsp.out_index == $past(cmd.particle_index, 3))
        else $error("load result missing or wrong index");

endmodule

bind cube_surface_particle_step_core csps_check #(.PARTICLES(PARTICLES)) u_csps_check (.*);
